### rtl/segint_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segint_pkg: shared widths, types and helpers
// Widths follow from the coordinate width; structs travel down the pipeline.
// ----------------------------------------------------------------------------
package segint_pkg;

    localparam int COORD_BITS = 16;

    // arithmetic widths
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * COORD_BITS + 2;
    localparam int DEN_W    = PROD_W + 1;
    localparam int CA_W     = 2 * COORD_BITS + 1;
    localparam int MUL_W    = CA_W + DIFF_W;
    localparam int NUM_W    = MUL_W + 1;
    localparam int QX_W     = 3 * COORD_BITS;
    localparam int XS_W     = QX_W + 1;
    localparam int XLO_W    = 2 * COORD_BITS;
    localparam int XHI_W    = XS_W - XLO_W;
    localparam int PH_W     = DIFF_W + XHI_W;
    localparam int PL_W     = DIFF_W + XLO_W + 1;
    localparam int NQ_W     = 4 * COORD_BITS;
    localparam int YN_W     = NQ_W + 3;
    localparam int YS_W     = NQ_W + 2;
    localparam int DV_W     = 2 * COORD_BITS + 1;

    // divider chain lengths and total latency
    localparam int XCELLS   = QX_W;
    localparam int YCELLS   = NQ_W;
    localparam int PIPE_LAT = 7 * COORD_BITS + 13;

    localparam logic signed [31:0] INT32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;

    // per-item side data carried alongside the arithmetic
    typedef struct packed {
        logic                     vert;
        logic                     pt_ok;
        logic                     neg;
        logic                     hit;
        coord_t                   xa1;
        coord_t                   ya1;
        coord_t                   xa2;
        coord_t                   ya2;
        coord_t                   xb1;
        coord_t                   xb2;
        diff_t                    dxa;
        diff_t                    dxb;
        diff_t                    dyb;
        logic signed [CA_W-1:0]   cb;
        logic signed [PROD_W-1:0] vnum;
        logic signed [XS_W-1:0]   xval;
    } seg_side_t;

    // one divider cell's contents
    typedef struct packed {
        seg_side_t         side;
        logic [NQ_W-1:0]   nq;
        logic [DV_W-1:0]   rem;
        logic [DV_W-1:0]   dvs;
    } div_data_t;

    // v within the span of p and q, ends included
    function automatic logic in_span(input logic signed [YS_W-1:0] v,
                                     input coord_t p, input coord_t q);
        logic signed [YS_W-1:0] ps;
        logic signed [YS_W-1:0] qs;
        logic signed [YS_W-1:0] lo;
        logic signed [YS_W-1:0] hi;
        ps = YS_W'(p);
        qs = YS_W'(q);
        lo = (ps < qs) ? ps : qs;
        hi = (ps < qs) ? qs : ps;
        return (v >= lo) && (v <= hi);
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [YS_W-1:0] v);
        logic signed [YS_W-1:0] mx;
        logic signed [YS_W-1:0] mn;
        mx = YS_W'(INT32_MAX);
        mn = YS_W'(INT32_MIN);
        if (v > mx)
            return INT32_MAX;
        else if (v < mn)
            return INT32_MIN;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

### rtl/segint_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segint_div_cell: one restoring division step
// Shifts one numerator bit into the remainder, subtracts the divisor when it
// fits and shifts the quotient bit into the low end of the numerator word.
// ----------------------------------------------------------------------------
module segint_div_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_vld,
    input  wire segint_pkg::div_data_t in_dat,
    output logic                       out_vld,
    output segint_pkg::div_data_t      out_dat
);

    logic                          vld_reg;
    segint_pkg::div_data_t         dat_reg;
    segint_pkg::div_data_t         dat_next;
    logic [segint_pkg::DV_W:0]     trial;
    logic [segint_pkg::DV_W:0]     diff;
    logic                          fits;

    // trial subtract
    always_comb
    begin
        trial    = {in_dat.rem, in_dat.nq[segint_pkg::NQ_W-1]};
        diff     = trial - {1'b0, in_dat.dvs};
        fits     = (trial >= {1'b0, in_dat.dvs});
        dat_next = in_dat;
        dat_next.rem = fits ? diff[segint_pkg::DV_W-1:0] : trial[segint_pkg::DV_W-1:0];
        dat_next.nq  = {in_dat.nq[segint_pkg::NQ_W-2:0], fits};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    // payload
    always_ff @(posedge clk)
    begin
        dat_reg <= dat_next;
    end

    assign out_vld = vld_reg;
    assign out_dat = dat_reg;

endmodule
`default_nettype wire

### rtl/segint_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segint_front: differences, products and x divider setup
// Six register stages from the input transfer to the x divider entry.
// ----------------------------------------------------------------------------
module segint_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_vld,
    input  wire segint_pkg::coord_t    xa1,
    input  wire segint_pkg::coord_t    ya1,
    input  wire segint_pkg::coord_t    xa2,
    input  wire segint_pkg::coord_t    ya2,
    input  wire segint_pkg::coord_t    xb1,
    input  wire segint_pkg::coord_t    yb1,
    input  wire segint_pkg::coord_t    xb2,
    input  wire segint_pkg::coord_t    yb2,
    output logic                       out_vld,
    output segint_pkg::div_data_t      out_dat
);

    logic [5:0] vld_reg;

    // stage 1: raw coordinates
    segint_pkg::seg_side_t   sd1_reg;
    segint_pkg::seg_side_t   sd1_next;
    segint_pkg::coord_t      yb1_1_reg;
    segint_pkg::coord_t      yb2_1_reg;

    // stage 2: differences
    segint_pkg::seg_side_t   sd2_reg;
    segint_pkg::seg_side_t   sd2_next;
    segint_pkg::diff_t       dya2_reg;
    segint_pkg::diff_t       dxv2_reg;
    segint_pkg::coord_t      yb1_2_reg;
    segint_pkg::coord_t      yb2_2_reg;

    // stage 3: products
    segint_pkg::seg_side_t                  sd3_reg;
    segint_pkg::seg_side_t                  sd3_next;
    logic signed [segint_pkg::PROD_W-1:0]   pd1_reg;
    logic signed [segint_pkg::PROD_W-1:0]   pd2_reg;
    logic signed [segint_pkg::CA_W-1:0]     pa1_reg;
    logic signed [segint_pkg::CA_W-1:0]     pa2_reg;
    logic signed [segint_pkg::CA_W-1:0]     pb1_reg;
    logic signed [segint_pkg::CA_W-1:0]     pb2_reg;

    // stage 4: determinants
    segint_pkg::seg_side_t                  sd4_reg;
    segint_pkg::seg_side_t                  sd4_next;
    logic signed [segint_pkg::DEN_W-1:0]    den4_reg;
    logic signed [segint_pkg::CA_W-1:0]     ca4_reg;

    // stage 5: numerator products
    segint_pkg::seg_side_t                  sd5_reg;
    segint_pkg::seg_side_t                  sd5_next;
    logic signed [segint_pkg::DEN_W-1:0]    den5_reg;
    logic signed [segint_pkg::MUL_W-1:0]    m1_reg;
    logic signed [segint_pkg::MUL_W-1:0]    m2_reg;

    // stage 6: divider entry
    segint_pkg::div_data_t                  ent_reg;
    segint_pkg::div_data_t                  ent_next;
    logic signed [segint_pkg::NUM_W-1:0]    num;
    logic [segint_pkg::NUM_W-1:0]           num_mag;
    logic [segint_pkg::DEN_W-1:0]           den_mag;

    always_comb
    begin
        sd1_next      = '0;
        sd1_next.xa1  = xa1;
        sd1_next.ya1  = ya1;
        sd1_next.xa2  = xa2;
        sd1_next.ya2  = ya2;
        sd1_next.xb1  = xb1;
        sd1_next.xb2  = xb2;
    end

    // differences
    always_comb
    begin
        sd2_next      = sd1_reg;
        sd2_next.dxa  = segint_pkg::DIFF_W'(sd1_reg.xa2) - segint_pkg::DIFF_W'(sd1_reg.xa1);
        sd2_next.dxb  = segint_pkg::DIFF_W'(sd1_reg.xb2) - segint_pkg::DIFF_W'(sd1_reg.xb1);
        sd2_next.dyb  = segint_pkg::DIFF_W'(yb2_1_reg) - segint_pkg::DIFF_W'(yb1_1_reg);
        sd2_next.vert = (sd2_next.dxb == '0);
    end

    // vertical-case numerator
    always_comb
    begin
        sd3_next      = sd2_reg;
        sd3_next.vnum = segint_pkg::PROD_W'(dya2_reg) * segint_pkg::PROD_W'(dxv2_reg);
    end

    // line b constant
    always_comb
    begin
        sd4_next    = sd3_reg;
        sd4_next.cb = pb1_reg - pb2_reg;
    end

    // point exists
    always_comb
    begin
        sd5_next       = sd4_reg;
        sd5_next.pt_ok = sd4_reg.vert ? (sd4_reg.dxa != '0) : (den4_reg != '0);
    end

    // signed magnitudes for the x divider
    always_comb
    begin
        num      = segint_pkg::NUM_W'(m1_reg) - segint_pkg::NUM_W'(m2_reg);
        num_mag  = num[segint_pkg::NUM_W-1] ? segint_pkg::NUM_W'(-num)
                                             : segint_pkg::NUM_W'(num);
        den_mag  = den5_reg[segint_pkg::DEN_W-1] ? segint_pkg::DEN_W'(-den5_reg)
                                                  : segint_pkg::DEN_W'(den5_reg);
        ent_next          = '0;
        ent_next.side     = sd5_reg;
        ent_next.side.neg = num[segint_pkg::NUM_W-1] ^ den5_reg[segint_pkg::DEN_W-1];
        ent_next.nq       = {num_mag[segint_pkg::QX_W-1:0],
                             {(segint_pkg::NQ_W - segint_pkg::QX_W){1'b0}}};
        if (sd5_reg.pt_ok && !sd5_reg.vert)
            ent_next.dvs = den_mag[segint_pkg::DV_W-1:0];
        else
            ent_next.dvs = segint_pkg::DV_W'(1);
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[4:0], in_vld};
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        sd1_reg   <= sd1_next;
        yb1_1_reg <= yb1;
        yb2_1_reg <= yb2;

        sd2_reg   <= sd2_next;
        dya2_reg  <= segint_pkg::DIFF_W'(sd1_reg.ya2) - segint_pkg::DIFF_W'(sd1_reg.ya1);
        dxv2_reg  <= segint_pkg::DIFF_W'(sd1_reg.xb1) - segint_pkg::DIFF_W'(sd1_reg.xa1);
        yb1_2_reg <= yb1_1_reg;
        yb2_2_reg <= yb2_1_reg;

        sd3_reg   <= sd3_next;
        pd1_reg   <= segint_pkg::PROD_W'(dya2_reg) * segint_pkg::PROD_W'(sd2_reg.dxb);
        pd2_reg   <= segint_pkg::PROD_W'(sd2_reg.dyb) * segint_pkg::PROD_W'(sd2_reg.dxa);
        pa1_reg   <= segint_pkg::CA_W'(sd2_reg.xa1) * segint_pkg::CA_W'(sd2_reg.ya2);
        pa2_reg   <= segint_pkg::CA_W'(sd2_reg.ya1) * segint_pkg::CA_W'(sd2_reg.xa2);
        pb1_reg   <= segint_pkg::CA_W'(sd2_reg.xb1) * segint_pkg::CA_W'(yb2_2_reg);
        pb2_reg   <= segint_pkg::CA_W'(yb1_2_reg) * segint_pkg::CA_W'(sd2_reg.xb2);

        sd4_reg   <= sd4_next;
        den4_reg  <= segint_pkg::DEN_W'(pd1_reg) - segint_pkg::DEN_W'(pd2_reg);
        ca4_reg   <= pa1_reg - pa2_reg;

        sd5_reg   <= sd5_next;
        den5_reg  <= den4_reg;
        m1_reg    <= segint_pkg::MUL_W'(ca4_reg) * segint_pkg::MUL_W'(sd4_reg.dxb);
        m2_reg    <= segint_pkg::MUL_W'(sd4_reg.cb) * segint_pkg::MUL_W'(sd4_reg.dxa);

        ent_reg   <= ent_next;
    end

    assign out_vld = vld_reg[5];
    assign out_dat = ent_reg;

endmodule
`default_nettype wire

### rtl/segint_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segint_back: y result, range tests and saturation
// Three register stages from the y divider exit to the result ports.
// ----------------------------------------------------------------------------
module segint_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_vld,
    input  wire segint_pkg::div_data_t in_dat,
    output logic                       done,
    output logic                       hit,
    output logic                       point_valid,
    output logic signed [31:0]         cross_x,
    output logic signed [31:0]         cross_y
);

    logic [2:0]                             vld_reg;
    segint_pkg::seg_side_t                  sd1_reg;
    segint_pkg::seg_side_t                  sd2_reg;
    logic signed [segint_pkg::YS_W-1:0]     yq1_reg;
    logic signed [segint_pkg::YS_W-1:0]     yq_next;
    logic signed [segint_pkg::YS_W-1:0]     yv2_reg;
    logic signed [segint_pkg::YS_W-1:0]     yv_next;
    logic signed [segint_pkg::YS_W-1:0]     qs;
    logic                                   vhit;
    logic                                   hit_next;
    logic                                   pv_next;
    logic signed [31:0]                     cx_next;
    logic signed [31:0]                     cy_next;
    logic                                   hit_reg;
    logic                                   pv_reg;
    logic signed [31:0]                     cx_reg;
    logic signed [31:0]                     cy_reg;

    // apply quotient sign
    always_comb
    begin
        qs      = $signed(segint_pkg::YS_W'(in_dat.nq));
        yq_next = in_dat.side.neg ? -qs : qs;
    end

    // vertical case adds the start y of segment a
    always_comb
    begin
        if (sd1_reg.vert)
            yv_next = yq1_reg + segint_pkg::YS_W'(sd1_reg.ya1);
        else
            yv_next = yq1_reg;
    end

    // flags and clamped point
    always_comb
    begin
        vhit = sd2_reg.pt_ok && segint_pkg::in_span(yv2_reg, sd2_reg.ya1, sd2_reg.ya2);
        if (sd2_reg.vert)
        begin
            hit_next = vhit;
            pv_next  = vhit;
        end
        else
        begin
            hit_next = sd2_reg.pt_ok && sd2_reg.hit;
            pv_next  = sd2_reg.pt_ok;
        end
        cx_next = pv_next ? segint_pkg::sat32(segint_pkg::YS_W'(sd2_reg.xval)) : '0;
        cy_next = pv_next ? segint_pkg::sat32(yv2_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        sd1_reg <= in_dat.side;
        yq1_reg <= yq_next;
        sd2_reg <= sd1_reg;
        yv2_reg <= yv_next;
        hit_reg <= hit_next;
        pv_reg  <= pv_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
    end

    assign done        = vld_reg[2];
    assign hit         = hit_reg;
    assign point_valid = pv_reg;
    assign cross_x     = cx_reg;
    assign cross_y     = cy_reg;

endmodule
`default_nettype wire

### rtl/segment_intersection_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_top: crossing point of two line segments
// Pipelined front end, two chains of restoring divider cells (x then y),
// and output stages with range tests and 32-bit saturation.
//
//   channel   handshake          payload
//   input     start / busy       seg_a_*, seg_b_* (8 signed coordinates)
//   result    done (one cycle)   hit, point_valid, cross_x, cross_y
//
// One pair is taken every cycle; busy is always low.
// The pipeline has six front stages, 3*COORD_BITS x divider cells, four
// middle stages, 4*COORD_BITS y divider cells and three output stages,
// one quotient bit per cell.
// Reset clears only the valid bits of the pipeline.
// Results appear once on done and cannot be held off.
// ----------------------------------------------------------------------------
module segment_intersection_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire segint_pkg::coord_t         seg_a_start_x,
    input  wire segint_pkg::coord_t         seg_a_start_y,
    input  wire segint_pkg::coord_t         seg_a_end_x,
    input  wire segint_pkg::coord_t         seg_a_end_y,
    input  wire segint_pkg::coord_t         seg_b_start_x,
    input  wire segint_pkg::coord_t         seg_b_start_y,
    input  wire segint_pkg::coord_t         seg_b_end_x,
    input  wire segint_pkg::coord_t         seg_b_end_y,
    output logic                            done,
    output logic                            hit,
    output logic                            point_valid,
    output logic signed [31:0]              cross_x,
    output logic signed [31:0]              cross_y
);

    logic                  x_vld [0:segint_pkg::XCELLS];
    segint_pkg::div_data_t x_dat [0:segint_pkg::XCELLS];
    logic                  y_vld [0:segint_pkg::YCELLS];
    segint_pkg::div_data_t y_dat [0:segint_pkg::YCELLS];

    logic [3:0]                                 mvld_reg;
    segint_pkg::seg_side_t                      m1_reg;
    segint_pkg::seg_side_t                      m1_next;
    segint_pkg::seg_side_t                      m2_reg;
    segint_pkg::seg_side_t                      m2_next;
    segint_pkg::seg_side_t                      m3_reg;
    logic signed [segint_pkg::PH_W-1:0]         ph_reg;
    logic signed [segint_pkg::PL_W-1:0]         pl_reg;
    logic signed [segint_pkg::YN_W-1:0]         ysum_reg;
    segint_pkg::div_data_t                      ent_reg;
    segint_pkg::div_data_t                      ent_next;
    logic signed [segint_pkg::XS_W-1:0]         xq;
    logic [segint_pkg::XLO_W-1:0]               xlo;
    logic signed [segint_pkg::XHI_W-1:0]        xhi;
    logic [segint_pkg::YN_W-1:0]                ysum_mag;
    logic [segint_pkg::PROD_W-1:0]              vnum_mag;
    logic [segint_pkg::DIFF_W-1:0]              dxa_mag;
    logic [segint_pkg::DIFF_W-1:0]              dxb_mag;

    assign busy = 1'b0;

    // front end
    segint_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start),
        .xa1     (seg_a_start_x),
        .ya1     (seg_a_start_y),
        .xa2     (seg_a_end_x),
        .ya2     (seg_a_end_y),
        .xb1     (seg_b_start_x),
        .yb1     (seg_b_start_y),
        .xb2     (seg_b_end_x),
        .yb2     (seg_b_end_y),
        .out_vld (x_vld[0]),
        .out_dat (x_dat[0])
    );

    // x divider chain
    genvar gi;
    generate
        for (gi = 0; gi < segint_pkg::XCELLS; gi++)
        begin : g_xcell
            segint_div_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .in_vld  (x_vld[gi]),
                .in_dat  (x_dat[gi]),
                .out_vld (x_vld[gi+1]),
                .out_dat (x_dat[gi+1])
            );
        end
    endgenerate

    // signed x, or segment b's x in the vertical case
    always_comb
    begin
        xq = $signed(segint_pkg::XS_W'(x_dat[segint_pkg::XCELLS].nq[segint_pkg::QX_W-1:0]));
        m1_next = x_dat[segint_pkg::XCELLS].side;
        if (m1_next.vert)
            m1_next.xval = segint_pkg::XS_W'(m1_next.xb1);
        else
            m1_next.xval = m1_next.neg ? -xq : xq;
    end

    // x range test on both segments
    always_comb
    begin
        xlo = m1_reg.xval[segint_pkg::XLO_W-1:0];
        xhi = m1_reg.xval[segint_pkg::XS_W-1:segint_pkg::XLO_W];
        m2_next     = m1_reg;
        m2_next.hit = segint_pkg::in_span(segint_pkg::YS_W'(m1_reg.xval), m1_reg.xa1, m1_reg.xa2)
                   && segint_pkg::in_span(segint_pkg::YS_W'(m1_reg.xval), m1_reg.xb1, m1_reg.xb2);
    end

    // y divider setup
    always_comb
    begin
        ysum_mag = ysum_reg[segint_pkg::YN_W-1] ? segint_pkg::YN_W'(-ysum_reg)
                                                 : segint_pkg::YN_W'(ysum_reg);
        vnum_mag = m3_reg.vnum[segint_pkg::PROD_W-1] ? segint_pkg::PROD_W'(-m3_reg.vnum)
                                                      : segint_pkg::PROD_W'(m3_reg.vnum);
        dxa_mag  = m3_reg.dxa[segint_pkg::DIFF_W-1] ? segint_pkg::DIFF_W'(-m3_reg.dxa)
                                                     : segint_pkg::DIFF_W'(m3_reg.dxa);
        dxb_mag  = m3_reg.dxb[segint_pkg::DIFF_W-1] ? segint_pkg::DIFF_W'(-m3_reg.dxb)
                                                     : segint_pkg::DIFF_W'(m3_reg.dxb);
        ent_next      = '0;
        ent_next.side = m3_reg;
        if (m3_reg.vert)
        begin
            ent_next.nq       = segint_pkg::NQ_W'(vnum_mag);
            ent_next.dvs      = segint_pkg::DV_W'(dxa_mag);
            ent_next.side.neg = m3_reg.vnum[segint_pkg::PROD_W-1]
                              ^ m3_reg.dxa[segint_pkg::DIFF_W-1];
        end
        else
        begin
            ent_next.nq       = ysum_mag[segint_pkg::NQ_W-1:0];
            ent_next.dvs      = segint_pkg::DV_W'(dxb_mag);
            ent_next.side.neg = ysum_reg[segint_pkg::YN_W-1]
                              ^ m3_reg.dxb[segint_pkg::DIFF_W-1];
        end
        if (!m3_reg.pt_ok)
            ent_next.dvs = segint_pkg::DV_W'(1);
    end

    // middle valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mvld_reg <= '0;
        else
            mvld_reg <= {mvld_reg[2:0], x_vld[segint_pkg::XCELLS]};
    end

    // middle payload pipeline
    always_ff @(posedge clk)
    begin
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        ph_reg   <= segint_pkg::PH_W'(m1_reg.dyb) * segint_pkg::PH_W'(xhi);
        pl_reg   <= segint_pkg::PL_W'(m1_reg.dyb) * $signed({1'b0, xlo});
        m3_reg   <= m2_reg;
        ysum_reg <= (segint_pkg::YN_W'(ph_reg) <<< segint_pkg::XLO_W)
                  + segint_pkg::YN_W'(pl_reg) - segint_pkg::YN_W'(m2_reg.cb);
        ent_reg  <= ent_next;
    end

    assign y_vld[0] = mvld_reg[3];
    assign y_dat[0] = ent_reg;

    // y divider chain
    genvar gj;
    generate
        for (gj = 0; gj < segint_pkg::YCELLS; gj++)
        begin : g_ycell
            segint_div_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .in_vld  (y_vld[gj]),
                .in_dat  (y_dat[gj]),
                .out_vld (y_vld[gj+1]),
                .out_dat (y_dat[gj+1])
            );
        end
    endgenerate

    // output stages
    segint_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (y_vld[segint_pkg::YCELLS]),
        .in_dat      (y_dat[segint_pkg::YCELLS]),
        .done        (done),
        .hit         (hit),
        .point_valid (point_valid),
        .cross_x     (cross_x),
        .cross_y     (cross_y)
    );

    // every transfer in gives one result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(segint_pkg::PIPE_LAT) done)
        else $error("result missing after input transfer");

    // a hit always carries a point
    a_hit_pt: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> point_valid)
        else $error("hit without valid point");

    // no point means a zero point
    a_zero_pt: assert property (@(posedge clk) disable iff (!rst_n)
        done && !point_valid |-> (cross_x == '0) && (cross_y == '0))
        else $error("nonzero point without point_valid");

endmodule
`default_nettype wire
